[hw/rtl/rc6_pkg.sv]
`default_nettype none

package rc6_pkg;

   localparam logic [31:0] MAGIC_P = 32'hB7E15163;
   localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

   localparam logic [1:0] CMD_ENCRYPT = 2'd0;
   localparam logic [1:0] CMD_DECRYPT = 2'd1;
   localparam logic [1:0] CMD_EXPAND  = 2'd2;

   localparam logic [2:0] REG_KEY_0  = 3'd0;
   localparam logic [2:0] REG_KEY_1  = 3'd1;
   localparam logic [2:0] REG_KEY_2  = 3'd2;
   localparam logic [2:0] REG_KEY_3  = 3'd3;
   localparam logic [2:0] REG_SERIAL = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] in_word_a;
      logic [31:0] in_word_b;
      logic [31:0] in_word_c;
      logic [31:0] in_word_d;
   } req_type;

   typedef struct packed {
      logic [31:0] out_word_a;
      logic [31:0] out_word_b;
      logic [31:0] out_word_c;
      logic [31:0] out_word_d;
      logic        key_missing;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] w;
      w = {x, x} << s;
      return w[63:32];
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] w;
      w = {x, x} >> s;
      return w[31:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rc6_rk_ram.sv]
`default_nettype none

module rc6_rk_ram #(
   parameter int DEPTH  = 84,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [31:0]       wdata,
   input  wire logic [ADDR_W-1:0] raddr0,
   input  wire logic [ADDR_W-1:0] raddr1,
   output logic      [31:0]       rdata0,
   output logic      [31:0]       rdata1
);

   logic [31:0] ram [DEPTH];
   logic [31:0] rdata0_ff;
   logic [31:0] rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ram[waddr] <= wdata;
      end
      rdata0_ff <= ram[raddr0];
      rdata1_ff <= ram[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

`default_nettype wire

[hw/rtl/rc6_key_sched.sv]
`default_nettype none

module rc6_key_sched import rc6_pkg::*; #(
   parameter int ROUNDS    = 40,
   parameter int KEY_BYTES = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [8*KEY_BYTES-1:0]      key_bytes,
   input  wire logic [31:0]                 serial_key,
   output logic                             mem_we,
   output logic [$clog2(ROUNDS+2):0]        mem_waddr,
   output logic [31:0]                      mem_wdata,
   output logic [$clog2(ROUNDS+2):0]        mem_raddr,
   input  wire logic [31:0]                 mem_rdata,
   output unit_status_type                  status
);

   localparam int TABLE_WORDS = 2 * ROUNDS + 4;
   localparam int ADDR_W      = $clog2(ROUNDS + 2) + 1;
   localparam int KEY_WORDS   = (KEY_BYTES + 3) / 4;
   localparam int KI_W        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
   localparam int STEPS       = 3 * ((KEY_WORDS > TABLE_WORDS) ? KEY_WORDS : TABLE_WORDS);
   localparam int STEP_W      = $clog2(STEPS);
   localparam int JW          = $clog2(KEY_BYTES);

   localparam logic [2:0] KS_IDLE  = 3'd0;
   localparam logic [2:0] KS_LOAD  = 3'd1;
   localparam logic [2:0] KS_FILL  = 3'd2;
   localparam logic [2:0] KS_MIX_A = 3'd3;
   localparam logic [2:0] KS_MIX_B = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [JW-1:0]     j_ff, j_in;
   logic [1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0] ti_ff, ti_in;
   logic [KI_W-1:0]   ki_ff, ki_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       a_ff, a_in;
   logic [31:0]       b_ff, b_in;
   logic              done_ff, done_in;

   logic [31:0]       mix_ff [KEY_WORDS];
   logic              mix_we;
   logic [KI_W-1:0]   mix_idx;
   logic [31:0]       mix_wdata;

   logic [KI_W-1:0]   wi;
   logic              top_byte;
   logic [7:0]        kb;
   logic [7:0]        sb;
   logic [31:0]       mix_base;
   logic [31:0]       a_new;
   logic [31:0]       ab_sum;
   logic [31:0]       b_new;
   logic [ADDR_W-1:0] ti_next;
   logic [KI_W-1:0]   ki_next;

   // byte j of the key, its word, and the serial byte that goes with it
   assign wi       = KI_W'(j_ff >> 2);
   assign top_byte = (j_ff == JW'(KEY_BYTES - 1)) || (j_ff[1:0] == 2'b11);
   assign kb       = key_bytes[8*j_ff +: 8];
   assign sb       = serial_key[8*idx_ff +: 8];
   assign mix_base = top_byte ? 32'd0 : {mix_ff[wi][23:0], 8'h00};

   assign a_new   = rotl32(mem_rdata + a_ff + b_ff, 5'd3);
   assign ab_sum  = a_ff + b_ff;
   assign b_new   = rotl32(mix_ff[ki_ff] + ab_sum, ab_sum[4:0]);
   assign ti_next = (ti_ff == ADDR_W'(TABLE_WORDS - 1)) ? '0 : ti_ff + 1'b1;
   assign ki_next = (ki_ff == KI_W'(KEY_WORDS - 1)) ? '0 : ki_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      j_in      = j_ff;
      idx_in    = idx_ff;
      ti_in     = ti_ff;
      ki_in     = ki_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      done_in   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = ti_ff;
      mem_wdata = acc_ff;
      mem_raddr = '0;
      mix_we    = 1'b0;
      mix_idx   = wi;
      mix_wdata = mix_base + {24'd0, kb} + {{24{sb[7]}}, sb};
      unique case (phase_ff)
         KS_IDLE: begin
            if (start) begin
               j_in     = JW'(KEY_BYTES - 1);
               idx_in   = 2'd0;
               phase_in = KS_LOAD;
            end
         end
         KS_LOAD: begin
            mix_we = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (j_ff == '0) begin
               ti_in    = '0;
               acc_in   = MAGIC_P;
               phase_in = KS_FILL;
            end else begin
               j_in = j_ff - 1'b1;
            end
         end
         KS_FILL: begin
            mem_we = 1'b1;
            acc_in = acc_ff + MAGIC_Q;
            if (ti_ff == ADDR_W'(TABLE_WORDS - 1)) begin
               mem_raddr = '0;
               ti_in     = '0;
               ki_in     = '0;
               a_in      = '0;
               b_in      = '0;
               step_in   = '0;
               phase_in  = KS_MIX_A;
            end else begin
               ti_in = ti_ff + 1'b1;
            end
         end
         KS_MIX_A: begin
            // table word read last cycle; write it back mixed
            mem_we    = 1'b1;
            mem_wdata = a_new;
            a_in      = a_new;
            phase_in  = KS_MIX_B;
         end
         KS_MIX_B: begin
            mix_we    = 1'b1;
            mix_idx   = ki_ff;
            mix_wdata = b_new;
            b_in      = b_new;
            ti_in     = ti_next;
            ki_in     = ki_next;
            mem_raddr = ti_next;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               done_in  = 1'b1;
               phase_in = KS_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               phase_in = KS_MIX_A;
            end
         end
         default: begin
            phase_in = KS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= KS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      j_ff    <= j_in;
      idx_ff  <= idx_in;
      ti_ff   <= ti_in;
      ki_ff   <= ki_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      if (mix_we) begin
         mix_ff[mix_idx] <= mix_wdata;
      end
   end

   assign status.busy = (phase_ff != KS_IDLE);
   assign status.done = done_ff;

endmodule

`default_nettype wire

[hw/rtl/rc6_round_engine.sv]
`default_nettype none

module rc6_round_engine import rc6_pkg::*; #(
   parameter int ROUNDS = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire req_type                blk,
   input  wire logic [31:0]            serial_key,
   output logic [$clog2(ROUNDS+2):0]   raddr0,
   output logic [$clog2(ROUNDS+2):0]   raddr1,
   input  wire logic [31:0]            rdata0,
   input  wire logic [31:0]            rdata1,
   output unit_status_type             status,
   output rsp_type                     result
);

   localparam int PAIR_W    = $clog2(ROUNDS + 2);
   localparam int LAST_PAIR = ROUNDS + 1;

   localparam logic [1:0] RE_IDLE  = 2'd0;
   localparam logic [1:0] RE_PRE   = 2'd1;
   localparam logic [1:0] RE_ROUND = 2'd2;
   localparam logic [1:0] RE_POST  = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic              dec_ff, dec_in;
   logic [PAIR_W-1:0] r_ff, r_in;
   logic [31:0]       a_ff, a_in;
   logic [31:0]       b_ff, b_in;
   logic [31:0]       c_ff, c_in;
   logic [31:0]       d_ff, d_in;
   logic              done_ff, done_in;

   logic [PAIR_W-1:0] pair_next;
   logic              last_round;
   logic [31:0]       t, u;
   logic [31:0]       enc_a, enc_c;
   logic [31:0]       dec_a, dec_c;

   function automatic logic [31:0] quad_mix(input logic [31:0] x);
      logic [31:0] p;
      p = x * {x[30:0], 1'b1};
      return rotl32(p, 5'd5);
   endfunction

   // share two multipliers between directions
   assign t = quad_mix(dec_ff ? a_ff : b_ff);
   assign u = quad_mix(dec_ff ? c_ff : d_ff);

   assign enc_a = rotl32(a_ff ^ t, u[4:0]) + rdata0;
   assign enc_c = rotl32(c_ff ^ u, t[4:0]) + rdata1;
   assign dec_a = rotr32(d_ff - rdata0, u[4:0]) ^ t;
   assign dec_c = rotr32(b_ff - rdata1, t[4:0]) ^ u;

   assign last_round = dec_ff ? (r_ff == PAIR_W'(1)) : (r_ff == PAIR_W'(ROUNDS));

   // key pair fetched for the next cycle
   always_comb begin
      case (phase_ff)
         RE_IDLE:  pair_next = (blk.cmd == CMD_DECRYPT) ? PAIR_W'(LAST_PAIR) : '0;
         RE_PRE:   pair_next = dec_ff ? PAIR_W'(ROUNDS) : PAIR_W'(1);
         RE_ROUND: pair_next = dec_ff ? r_ff - 1'b1 : r_ff + 1'b1;
         default:  pair_next = '0;
      endcase
   end

   assign raddr0 = {pair_next, 1'b0};
   assign raddr1 = {pair_next, 1'b1};

   always_comb begin
      phase_in = phase_ff;
      dec_in   = dec_ff;
      r_in     = r_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         RE_IDLE: begin
            if (start) begin
               a_in     = blk.in_word_a;
               b_in     = blk.in_word_b;
               c_in     = blk.in_word_c;
               d_in     = blk.in_word_d;
               dec_in   = (blk.cmd == CMD_DECRYPT);
               phase_in = RE_PRE;
            end
         end
         RE_PRE: begin
            r_in = pair_next;
            if (dec_ff) begin
               a_in = (a_ff ^ serial_key) - rdata0;
               b_in = b_ff ^ serial_key;
               c_in = (c_ff ^ serial_key) - rdata1;
               d_in = d_ff ^ serial_key;
            end else begin
               b_in = b_ff + rdata0;
               d_in = d_ff + rdata1;
            end
            phase_in = RE_ROUND;
         end
         RE_ROUND: begin
            r_in = pair_next;
            if (dec_ff) begin
               a_in = dec_a;
               b_in = a_ff;
               c_in = dec_c;
               d_in = c_ff;
            end else begin
               a_in = b_ff;
               b_in = enc_c;
               c_in = d_ff;
               d_in = enc_a;
            end
            if (last_round) begin
               phase_in = RE_POST;
            end
         end
         RE_POST: begin
            if (dec_ff) begin
               b_in = b_ff - rdata0;
               d_in = d_ff - rdata1;
            end else begin
               a_in = (a_ff + rdata0) ^ serial_key;
               b_in = b_ff ^ serial_key;
               c_in = (c_ff + rdata1) ^ serial_key;
               d_in = d_ff ^ serial_key;
            end
            done_in  = 1'b1;
            phase_in = RE_IDLE;
         end
         default: begin
            phase_in = RE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RE_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      dec_ff <= dec_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
   end

   assign status.busy = (phase_ff != RE_IDLE);
   assign status.done = done_ff;

   assign result.out_word_a  = a_ff;
   assign result.out_word_b  = b_ff;
   assign result.out_word_c  = c_ff;
   assign result.out_word_d  = d_ff;
   assign result.key_missing = 1'b0;

endmodule

`default_nettype wire

[hw/rtl/rc6_block_cipher_core.sv]
// Encrypt/decrypt: one round per cycle on a dual-read round-key RAM. A new beat is taken
// only after the last command's result has moved into the output register.
// Key setup: one key byte, then one table word, per cycle; each mix step then runs
// through the states KS_MIX_A and KS_MIX_B.
// Commands that return at once (no key yet, unused code) start neither unit.
// Reset (synchronous) clears control, CSRs and the key-valid flag; the table is not swept.
`default_nettype none

module rc6_block_cipher_core import rc6_pkg::*; #(
   parameter int ROUNDS    = 40,
   parameter int KEY_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   localparam int TABLE_WORDS = 2 * ROUNDS + 4;
   localparam int ADDR_W      = $clog2(ROUNDS + 2) + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_CRYPT = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // ------------------------------------------------------------------
   // CSRs: four 64-bit key registers and the serial key, 8-byte stride
   // ------------------------------------------------------------------
   logic [63:0] key_ff [4];
   logic [63:0] key_in [4];
   logic [31:0] serial_ff, serial_in;
   logic [2:0]  csr_index;
   logic        csr_write;
   logic [255:0] key_flat;

   assign csr_index = paddr[5:3];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign key_flat  = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};

   always_comb begin
      key_in    = key_ff;
      serial_in = serial_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_KEY_0:  key_in[0] = pwdata;
            REG_KEY_1:  key_in[1] = pwdata;
            REG_KEY_2:  key_in[2] = pwdata;
            REG_KEY_3:  key_in[3] = pwdata;
            REG_SERIAL: serial_in = pwdata[31:0];
            default:    ; // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY_0:  prdata = key_ff[0];
         REG_KEY_1:  prdata = key_ff[1];
         REG_KEY_2:  prdata = key_ff[2];
         REG_KEY_3:  prdata = key_ff[3];
         REG_SERIAL: prdata = {32'd0, serial_ff};
         default:    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Round-key RAM, shared by the key scheduler (port 0 + write) and the
   // round engine (both read ports). The two never run at once, and the
   // scheduler's read-modify-write never uses a read of an entry it is writing.
   // ------------------------------------------------------------------
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [31:0]       mem_wdata;
   logic [ADDR_W-1:0] mem_raddr0, mem_raddr1;
   logic [31:0]       mem_rdata0, mem_rdata1;
   logic [ADDR_W-1:0] ks_raddr;
   logic [ADDR_W-1:0] eng_raddr0;

   unit_status_type   ks_st;
   unit_status_type   eng_st;
   rsp_type           eng_result;
   logic              ks_start;
   logic              eng_start;

   assign mem_raddr0 = ks_st.busy ? ks_raddr : eng_raddr0;

   rc6_rk_ram #(
      .DEPTH  (TABLE_WORDS),
      .ADDR_W (ADDR_W)
   ) u_rk_ram (
      .clock  (clock),
      .we     (mem_we),
      .waddr  (mem_waddr),
      .wdata  (mem_wdata),
      .raddr0 (mem_raddr0),
      .raddr1 (mem_raddr1),
      .rdata0 (mem_rdata0),
      .rdata1 (mem_rdata1)
   );

   rc6_key_sched #(
      .ROUNDS    (ROUNDS),
      .KEY_BYTES (KEY_BYTES)
   ) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (ks_start),
      .key_bytes  (key_flat[8*KEY_BYTES-1:0]),
      .serial_key (serial_ff),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (ks_raddr),
      .mem_rdata  (mem_rdata0),
      .status     (ks_st)
   );

   rc6_round_engine #(
      .ROUNDS (ROUNDS)
   ) u_round_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (eng_start),
      .blk        (req_data),
      .serial_key (serial_ff),
      .raddr0     (eng_raddr0),
      .raddr1     (mem_raddr1),
      .rdata0     (mem_rdata0),
      .rdata1     (mem_rdata1),
      .status     (eng_st),
      .result     (eng_result)
   );

   // ------------------------------------------------------------------
   // Command sequencer and output register. One command at a time; a new
   // beat is taken in idle even while the last response is still stalled.
   // ------------------------------------------------------------------
   logic [1:0] state_ff, state_in;
   logic       keys_valid_ff, keys_valid_in;
   rsp_type    res_ff, res_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      keys_valid_in = keys_valid_ff;
      res_in        = res_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      ks_start      = 1'b0;
      eng_start     = 1'b0;
      // retire the response beat once taken
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               unique case (req_data.cmd) inside
                  CMD_EXPAND: begin
                     ks_start = 1'b1;
                     state_in = ST_SETUP;
                  end
                  CMD_ENCRYPT, CMD_DECRYPT: begin
                     if (keys_valid_ff) begin
                        eng_start = 1'b1;
                        state_in  = ST_CRYPT;
                     end else begin
                        res_in.key_missing = 1'b1;
                        state_in           = ST_DONE;
                     end
                  end
                  default: begin
                     // unused code: zero response, keys left unchanged
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            if (ks_st.done) begin
               keys_valid_in = 1'b1;
               res_in        = '0;
               state_in      = ST_DONE;
            end
         end
         ST_CRYPT: begin
            if (eng_st.done) begin
               res_in   = eng_result;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keys_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         key_ff[0]     <= '0;
         key_ff[1]     <= '0;
         key_ff[2]     <= '0;
         key_ff[3]     <= '0;
         serial_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         keys_valid_ff <= keys_valid_in;
         out_valid_ff  <= out_valid_in;
         key_ff        <= key_in;
         serial_ff     <= serial_in;
      end
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ks_st.busy && eng_st.busy))
      else $error("key scheduler and round engine share the RAM at once");

   a_crypt_needs_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRYPT) |-> keys_valid_ff)
      else $error("block processed without an expanded key table");

   a_eng_done_in_crypt: assert property (@(posedge clock) disable iff (reset)
      eng_st.done |-> (state_ff == ST_CRYPT))
      else $error("round engine finished outside a block command");

   a_ks_done_in_setup: assert property (@(posedge clock) disable iff (reset)
      ks_st.done |-> (state_ff == ST_SETUP) && !eng_st.busy)
      else $error("key scheduler finished outside a key setup");

endmodule

`default_nettype wire

[verif/tb_rc6_block_cipher_core.sv]
`timescale 1ns / 1ps

module tb_rc6_block_cipher_core;
   import rc6_pkg::*;

   localparam int ROUNDS      = 40;
   localparam int KEY_BYTES   = 32;
   localparam int KEY_WORDS   = (KEY_BYTES + 3) / 4;
   localparam int TABLE_WORDS = 2 * ROUNDS + 4;
   localparam int MIX_STEPS   = 3 * (KEY_WORDS > TABLE_WORDS ? KEY_WORDS : TABLE_WORDS);
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = ROUNDS + 12;

   // command code that the block must treat as a no-op
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // register index that decodes to nothing
   localparam logic [2:0] REG_UNUSED = 3'd5;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   rc6_block_cipher_core #(
      .ROUNDS    (ROUNDS),
      .KEY_BYTES (KEY_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the cipher state: CSRs, the round-key table and the
   // key-ready flag. Updated only by accepted beats and CSR writes.
   // ------------------------------------------------------------------
   logic [63:0] key_reg [0:3];
   logic [31:0] serial_word;
   logic [31:0] round_key [0:TABLE_WORDS-1];
   bit          key_ready;

   rsp_type expected_blocks [$];
   int      errors;
   int      cycle_count;
   bit      calm;   // when set, both sides run without idle cycles

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input logic [31:0] s);
      logic [4:0] n;
      n = s[4:0];
      // a shift by 32 yields zero, so a zero amount needs no special case
      return (x << n) | (x >> (6'd32 - n));
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input logic [31:0] s);
      logic [4:0] n;
      n = s[4:0];
      return (x >> n) | (x << (6'd32 - n));
   endfunction

   function automatic logic [31:0] quad_mix(input logic [31:0] x);
      return rol(x * (32'd2 * x + 32'd1), 32'd5);
   endfunction

   // Build the round-key table from the key bytes and the serial word.
   function automatic void expand_round_keys();
      logic [31:0] mix [0:7];
      logic [31:0] ext;
      logic [31:0] a;
      logic [31:0] b;
      int          sel;
      int          ti;
      int          ki;
      for (int w = 0; w < 8; w++) mix[w] = '0;
      // walk key bytes from the top; serial bytes rotate from byte 0 up
      for (int j = KEY_BYTES - 1; j >= 0; j--) begin
         sel = (KEY_BYTES - 1 - j) % 4;
         ext = {{24{serial_word[8*sel+7]}}, serial_word[8*sel +: 8]};
         mix[(j / 4) % 8] = (mix[(j / 4) % 8] << 8)
                          + {24'd0, key_reg[(j / 8) % 4][8*(j % 8) +: 8]} + ext;
      end
      round_key[0] = MAGIC_P;
      for (int s = 1; s < TABLE_WORDS; s++) round_key[s] = round_key[s-1] + MAGIC_Q;
      a  = '0;
      b  = '0;
      ti = 0;
      ki = 0;
      for (int s = 0; s < MIX_STEPS; s++) begin
         round_key[ti] = rol(round_key[ti] + a + b, 32'd3);
         a = round_key[ti];
         mix[ki] = rol(mix[ki] + a + b, a + b);
         b = mix[ki];
         ti = (ti + 1) % TABLE_WORDS;
         ki = (ki + 1) % KEY_WORDS;
      end
      key_ready = 1'b1;
   endfunction

   function automatic rsp_type encrypt_block(input req_type q);
      logic [31:0] a, b, c, d, t, u, tmp;
      rsp_type     r;
      a = q.in_word_a;
      b = q.in_word_b + round_key[0];
      c = q.in_word_c;
      d = q.in_word_d + round_key[1];
      for (int i = 1; i <= ROUNDS; i++) begin
         t = quad_mix(b);
         u = quad_mix(d);
         a = rol(a ^ t, u) + round_key[2*i];
         c = rol(c ^ u, t) + round_key[2*i+1];
         tmp = a; a = b; b = c; c = d; d = tmp;
      end
      // whiten every ciphertext word with the serial word
      r.out_word_a  = (a + round_key[2*ROUNDS+2]) ^ serial_word;
      r.out_word_b  = b ^ serial_word;
      r.out_word_c  = (c + round_key[2*ROUNDS+3]) ^ serial_word;
      r.out_word_d  = d ^ serial_word;
      r.key_missing = 1'b0;
      return r;
   endfunction

   function automatic rsp_type decrypt_block(input req_type q);
      logic [31:0] a, b, c, d, t, u, tmp;
      rsp_type     r;
      // strip the whitening before undoing the rounds
      a = (q.in_word_a ^ serial_word) - round_key[2*ROUNDS+2];
      b = q.in_word_b ^ serial_word;
      c = (q.in_word_c ^ serial_word) - round_key[2*ROUNDS+3];
      d = q.in_word_d ^ serial_word;
      for (int i = ROUNDS; i > 0; i--) begin
         tmp = d; d = c; c = b; b = a; a = tmp;
         u = quad_mix(d);
         t = quad_mix(b);
         c = ror(c - round_key[2*i+1], t) ^ u;
         a = ror(a - round_key[2*i], u) ^ t;
      end
      r.out_word_a  = a;
      r.out_word_b  = b - round_key[0];
      r.out_word_c  = c;
      r.out_word_d  = d - round_key[1];
      r.key_missing = 1'b0;
      return r;
   endfunction

   // Result of one accepted beat; advances the shadow state as the block does.
   function automatic rsp_type cipher_result(input req_type q);
      rsp_type r;
      r = '0;
      case (q.cmd)
         CMD_EXPAND: expand_round_keys();
         CMD_UNUSED: r = '0;
         default: begin
            if (!key_ready) r.key_missing = 1'b1;
            else if (q.cmd == CMD_ENCRYPT) r = encrypt_block(q);
            else r = decrypt_block(q);
         end
      endcase
      return r;
   endfunction

   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_key_reg();
      case ($urandom_range(0, 7))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type make_beat(input logic [1:0] cmd, input logic [31:0] a,
                                          input logic [31:0] b, input logic [31:0] c,
                                          input logic [31:0] d);
      req_type q;
      q.cmd       = cmd;
      q.in_word_a = a;
      q.in_word_b = b;
      q.in_word_c = c;
      q.in_word_d = d;
      return q;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Result checker: compare every accepted result beat with the oldest
   // expectation, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: result with nothing expected, expected none actual %h",
                     $time, rsp_data);
            errors++;
         end else begin
            want = expected_blocks.pop_front();
            check_field("out_word_a", want.out_word_a, rsp_data.out_word_a);
            check_field("out_word_b", want.out_word_b, rsp_data.out_word_b);
            check_field("out_word_c", want.out_word_c, rsp_data.out_word_c);
            check_field("out_word_d", want.out_word_d, rsp_data.out_word_d);
            check_field("key_missing", {31'd0, want.key_missing},
                        {31'd0, rsp_data.key_missing});
         end
      end
   end

   // ------------------------------------------------------------------
   // Result-side backpressure: for each result draw a number of cycles to
   // hold stall while a result is offered, then let one beat through.
   // ------------------------------------------------------------------
   initial begin : rsp_backpressure
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = idle_draw();
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            // count only cycles where a result is actually held back
            while (hold > 0) begin
               @(posedge clock);
               if (rsp_valid) hold--;
            end
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // Send one beat: idle a drawn number of cycles, present it at the falling
   // edge, hold it until accepted, then record what it must produce.
   task automatic send_beat(input req_type q);
      int gap;
      gap = idle_draw();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_blocks.push_back(cipher_result(q));
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
   endtask

   // Write one register over the configuration port and, if it decodes to a register, read it back.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx < REG_SERIAL) key_reg[idx] = value;
      else if (idx == REG_SERIAL) serial_word = value[31:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx <= REG_SERIAL) begin
         @(negedge clock);
         psel    <= 1'b1;
         pwrite  <= 1'b0;
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         if (idx == REG_SERIAL) check_field("serial_key readback", value[31:0], prdata[31:0]);
         else begin
            check_field("key readback low", value[31:0], prdata[31:0]);
            check_field("key readback high", value[63:32], prdata[63:32]);
         end
         @(negedge clock);
         psel    <= 1'b0;
         penable <= 1'b0;
      end
   endtask

   // Go idle, load all key registers and the serial word, then expand.
   task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [31:0] serial);
      drain();
      csr_write(REG_KEY_0, k0);
      csr_write(REG_KEY_1, k1);
      csr_write(REG_KEY_2, k2);
      csr_write(REG_KEY_3, k3);
      csr_write(REG_SERIAL, {32'd0, serial});
      send_beat(make_beat(CMD_EXPAND, rand_word(), rand_word(), rand_word(), rand_word()));
   endtask

   // Blocks before any key setup must come back as zeros with the flag set; a no-op comes back all zero.
   task automatic test_block_before_key();
      send_beat(make_beat(CMD_ENCRYPT, '0, '0, '0, '0));
      send_beat(make_beat(CMD_DECRYPT, '1, '1, '1, '1));
      send_beat(make_beat(CMD_UNUSED, '1, '1, '1, '1));
   endtask

   // All-zero key and serial word, blocks at both extremes, and a no-op.
   task automatic test_zero_key();
      load_key('0, '0, '0, '0, '0);
      send_beat(make_beat(CMD_ENCRYPT, '0, '0, '0, '0));
      send_beat(make_beat(CMD_ENCRYPT, '1, '1, '1, '1));
      send_beat(make_beat(CMD_DECRYPT, '0, '0, '0, '0));
      send_beat(make_beat(CMD_DECRYPT, '1, '1, '1, '1));
      send_beat(make_beat(CMD_UNUSED, '0, '1, '0, '1));
   endtask

   // All-ones key and serial word: every serial byte sign-extends negative.
   task automatic test_full_key();
      load_key('1, '1, '1, '1, '1);
      send_beat(make_beat(CMD_ENCRYPT, '0, '0, '0, '0));
      send_beat(make_beat(CMD_ENCRYPT, '1, '1, '1, '1));
      send_beat(make_beat(CMD_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555));
   endtask

   // Serial bytes of both signs so both extension cases land in one key.
   task automatic test_sign_mixed_serial();
      load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
               64'h8080_8080_7F7F_7F7F, 64'h00FF_00FF_FF00_FF00, 32'h807F_80FF);
      send_beat(make_beat(CMD_ENCRYPT, 32'h0000_0001, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'hFFFF_FFFE));
      send_beat(make_beat(CMD_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                          32'hCAFE_BABE, 32'h1234_5678));
   endtask

   // Rewrite the serial word without a new setup: only the whitening moves.
   // Also poke an address that decodes to no register.
   task automatic test_serial_rewrite();
      drain();
      csr_write(REG_SERIAL, {32'd0, 32'h5A5A_A5A5});
      csr_write(REG_UNUSED, {$urandom, $urandom});
      send_beat(make_beat(CMD_ENCRYPT, rand_word(), rand_word(), rand_word(), rand_word()));
      send_beat(make_beat(CMD_DECRYPT, rand_word(), rand_word(), rand_word(), rand_word()));
   endtask

   // Random traffic in phases; each phase loads a fresh key and expands it,
   // then streams mostly cipher blocks with the odd no-op and re-expand.
   task automatic test_random_traffic();
      int      pick;
      req_type q;
      for (int p = 0; p < 8; p++) begin
         calm = 1'b0;
         load_key(rand_key_reg(), rand_key_reg(), rand_key_reg(), rand_key_reg(),
                  rand_word());
         for (int i = 0; i < 62; i++) begin
            // switch between idle-free stretches and gappy ones
            if (i % 16 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            q = make_beat(CMD_ENCRYPT, rand_word(), rand_word(), rand_word(), rand_word());
            if (pick >= 96) q.cmd = CMD_EXPAND;
            else if (pick >= 92) q.cmd = CMD_UNUSED;
            else if (pick >= 46) q.cmd = CMD_DECRYPT;
            send_beat(q);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      errors    = 0;
      calm      = 1'b0;
      key_ready = 1'b0;
      serial_word = '0;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_block_before_key();
      test_zero_key();
      test_full_key();
      test_sign_mixed_serial();
      test_serial_rewrite();
      test_random_traffic();

      // drain, then linger to catch any stray result beats
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_blocks.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
